// ===== rtl/segment_intersection_tolerant_assert.svh =====
// Assertion macros for the segment intersection RTL.
// Used by modules that carry concurrent checks; expects clk and rst in scope.
`ifndef SEGMENT_INTERSECTION_TOLERANT_ASSERT_SVH
`define SEGMENT_INTERSECTION_TOLERANT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SIT_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define SIT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");
`else
`define SIT_ASSERT(label, expr)
`define SIT_ASSERT_IMPL(label, ante, cons)
`endif
`endif

// ===== rtl/sit_pkg.sv =====
// Shared widths, payload structs and constants for the segment intersection block.
// No dependencies; the RTL modules all refer to it by scoped names.
package sit_pkg;

  localparam int CW    = 32;            // coordinate width
  localparam int DXW   = CW + 1;        // endpoint difference
  localparam int CPW   = 2 * CW;        // coordinate product
  localparam int PW    = 2 * DXW;       // difference product
  localparam int DETW  = PW + 1;        // determinant
  localparam int CAW   = CPW + 1;       // cross term
  localparam int LOW   = CW;            // low split of a cross term
  localparam int HIW   = CAW - LOW;     // high split of a cross term
  localparam int NW    = DXW + CAW + 1; // numerator
  localparam int QB    = 36;            // quotient bits kept, beyond is overflow
  localparam int QW    = QB + 1;        // signed quotient
  localparam int RW    = DETW + QB;     // divider remainder
  localparam int SSW   = PW;            // squared length
  localparam int SQB   = CW + 2;        // root bits
  localparam int SRW   = SSW + 2;       // root remainder
  localparam int EPSW  = SQB;
  localparam int TOLW  = 16;
  localparam int BW    = QW;            // widened bound
  localparam int DIV_LAT = QB + 3;

  localparam logic signed [QW-1:0] Q_MAX = (QW'(1) << (CW - 1)) - QW'(1);
  localparam logic signed [QW-1:0] Q_MIN = ~Q_MAX;
  localparam logic signed [CW-1:0] C_MAX = Q_MAX[CW-1:0];
  localparam logic signed [CW-1:0] C_MIN = Q_MIN[CW-1:0];

  typedef struct packed {
    logic signed [CW-1:0] a_start_x;
    logic signed [CW-1:0] a_start_y;
    logic signed [CW-1:0] a_end_x;
    logic signed [CW-1:0] a_end_y;
    logic signed [CW-1:0] b_start_x;
    logic signed [CW-1:0] b_start_y;
    logic signed [CW-1:0] b_end_x;
    logic signed [CW-1:0] b_end_y;
  } seg_in_t;

  typedef struct packed {
    logic                 hit;
    logic                 lines_parallel;
    logic signed [CW-1:0] cross_x;
    logic signed [CW-1:0] cross_y;
  } result_t;

  typedef struct packed {
    logic signed [CW-1:0] ax_lo;
    logic signed [CW-1:0] ax_hi;
    logic signed [CW-1:0] bx_lo;
    logic signed [CW-1:0] bx_hi;
    logic signed [CW-1:0] ay_lo;
    logic signed [CW-1:0] ay_hi;
    logic signed [CW-1:0] by_lo;
    logic signed [CW-1:0] by_hi;
    logic                 boxes;
  } bounds_t;

  typedef struct packed {
    logic signed [BW-1:0] ax_lo;
    logic signed [BW-1:0] ax_hi;
    logic signed [BW-1:0] bx_lo;
    logic signed [BW-1:0] bx_hi;
    logic signed [BW-1:0] ay_lo;
    logic signed [BW-1:0] ay_hi;
    logic signed [BW-1:0] by_lo;
    logic signed [BW-1:0] by_hi;
    logic                 boxes;
  } wide_bounds_t;

  typedef struct packed {
    seg_in_t               seg;
    logic signed [DXW-1:0] dxa;
    logic signed [DXW-1:0] dya;
    logic signed [DXW-1:0] dxb;
    logic signed [DXW-1:0] dyb;
    bounds_t               bnd;
  } item_t;

  typedef struct packed {
    logic                 ovf;
    logic                 neg;
    logic signed [QW-1:0] q;
  } div_res_t;

endpackage

// ===== rtl/sit_front.sv =====
// Front end: takes a request, then classifies it (differences, extents, box overlap).
// Depends on sit_pkg.
module sit_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  sit_pkg::seg_in_t segs,
  input  logic             full,
  output logic             push,
  output sit_pkg::item_t   item
);

  logic             valid;
  sit_pkg::seg_in_t seg;
  logic             accept;

  assign push   = valid && !full;
  assign busy   = valid && full;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (push) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seg <= segs;
    end
  end

  always_comb begin
    item.seg = seg;
    item.dxa = sit_pkg::DXW'(seg.a_start_x) - sit_pkg::DXW'(seg.a_end_x);
    item.dya = sit_pkg::DXW'(seg.a_start_y) - sit_pkg::DXW'(seg.a_end_y);
    item.dxb = sit_pkg::DXW'(seg.b_start_x) - sit_pkg::DXW'(seg.b_end_x);
    item.dyb = sit_pkg::DXW'(seg.b_start_y) - sit_pkg::DXW'(seg.b_end_y);
    item.bnd.ax_lo = (seg.a_start_x < seg.a_end_x) ? seg.a_start_x : seg.a_end_x;
    item.bnd.ax_hi = (seg.a_start_x > seg.a_end_x) ? seg.a_start_x : seg.a_end_x;
    item.bnd.ay_lo = (seg.a_start_y < seg.a_end_y) ? seg.a_start_y : seg.a_end_y;
    item.bnd.ay_hi = (seg.a_start_y > seg.a_end_y) ? seg.a_start_y : seg.a_end_y;
    item.bnd.bx_lo = (seg.b_start_x < seg.b_end_x) ? seg.b_start_x : seg.b_end_x;
    item.bnd.bx_hi = (seg.b_start_x > seg.b_end_x) ? seg.b_start_x : seg.b_end_x;
    item.bnd.by_lo = (seg.b_start_y < seg.b_end_y) ? seg.b_start_y : seg.b_end_y;
    item.bnd.by_hi = (seg.b_start_y > seg.b_end_y) ? seg.b_start_y : seg.b_end_y;
    item.bnd.boxes = !((item.bnd.ax_lo > item.bnd.bx_hi) || (item.bnd.bx_lo > item.bnd.ax_hi) ||
                       (item.bnd.ay_lo > item.bnd.by_hi) || (item.bnd.by_lo > item.bnd.ay_hi));
  end

endmodule

// ===== rtl/sit_queue.sv =====
// Two-entry queue between the front end and the arithmetic back end.
// Depends on sit_pkg.
module sit_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sit_pkg::item_t din,
  input  logic           pop,
  output sit_pkg::item_t dout,
  output logic           full,
  output logic           empty
);

  sit_pkg::item_t mem [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/sit_div.sv =====
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
// Flags quotients of more than QB bits as overflow. Depends on sit_pkg.
module sit_div (
  input  logic                              clk,
  input  logic signed [sit_pkg::NW-1:0]     num,
  input  logic signed [sit_pkg::DETW-1:0]   den,
  output sit_pkg::div_res_t                 res
);

  localparam int QB = sit_pkg::QB;
  localparam int RW = sit_pkg::RW;

  logic [sit_pkg::NW-1:0]   an;
  logic [sit_pkg::DETW-1:0] ad;
  logic                     neg_a;

  logic [RW-1:0]   r_q   [QB+1];
  logic [sit_pkg::DETW-1:0] d_q [QB+1];
  logic [QB-1:0]   q_q   [QB+1];
  logic            neg_q [QB+1];
  logic            ovf_q [QB+1];

  always_ff @(posedge clk) begin
    an    <= num[sit_pkg::NW-1] ? sit_pkg::NW'(-num) : sit_pkg::NW'(num);
    ad    <= den[sit_pkg::DETW-1] ? sit_pkg::DETW'(-den) : sit_pkg::DETW'(den);
    neg_a <= num[sit_pkg::NW-1] ^ den[sit_pkg::DETW-1];
  end

  // high quotient bits are all zero only if |n| < |d| * 2^QB
  always_ff @(posedge clk) begin
    r_q[0]   <= RW'(an);
    d_q[0]   <= ad;
    q_q[0]   <= '0;
    neg_q[0] <= neg_a;
    ovf_q[0] <= RW'(an) >= (RW'(ad) << QB);
  end

  for (genvar i = 0; i < QB; i++) begin : g_stage
    localparam int K = QB - 1 - i;
    logic [RW-1:0] trial;
    logic          ge;
    assign trial = RW'(d_q[i]) << K;
    assign ge    = r_q[i] >= trial;
    always_ff @(posedge clk) begin
      r_q[i+1]   <= ge ? r_q[i] - trial : r_q[i];
      q_q[i+1]   <= ge ? (q_q[i] | (QB'(1) << K)) : q_q[i];
      d_q[i+1]   <= d_q[i];
      neg_q[i+1] <= neg_q[i];
      ovf_q[i+1] <= ovf_q[i];
    end
  end

  always_ff @(posedge clk) begin
    res.ovf <= ovf_q[QB];
    res.neg <= neg_q[QB];
    res.q   <= neg_q[QB] ? -sit_pkg::QW'(q_q[QB]) : sit_pkg::QW'(q_q[QB]);
  end

endmodule

// ===== rtl/sit_sqrt.sv =====
// Pipelined integer square root, one root bit per stage (floor).
// Depends on sit_pkg.
module sit_sqrt (
  input  logic                      clk,
  input  logic [sit_pkg::SSW-1:0]   s,
  output logic [sit_pkg::SQB-1:0]   root
);

  localparam int SQB = sit_pkg::SQB;
  localparam int SRW = sit_pkg::SRW;

  logic [SRW-1:0] rem_in  [SQB];
  logic [SQB-1:0] root_in [SQB];
  logic [SRW-1:0] rem_q   [SQB];
  logic [SQB-1:0] root_q  [SQB];

  for (genvar i = 0; i < SQB; i++) begin : g_stage
    localparam int B = SQB - 1 - i;
    logic [SRW-1:0] trial;
    logic           ge;
    if (i == 0) begin : g_first
      assign rem_in[i]  = SRW'(s);
      assign root_in[i] = '0;
    end else begin : g_next
      assign rem_in[i]  = rem_q[i-1];
      assign root_in[i] = root_q[i-1];
    end
    // (r + 2^b)^2 <= s  <=>  s - r^2 >= r*2^(b+1) + 2^(2b)
    assign trial = (SRW'(root_in[i]) << (B + 1)) | (SRW'(1) << (2 * B));
    assign ge    = rem_in[i] >= trial;
    always_ff @(posedge clk) begin
      rem_q[i]  <= ge ? rem_in[i] - trial : rem_in[i];
      root_q[i] <= ge ? (root_in[i] | (SQB'(1) << B)) : root_in[i];
    end
  end

  assign root = root_q[SQB-1];

endmodule

// ===== rtl/sit_back.sv =====
// Back end: determinant, line intersection by division, lengths by square root,
// tolerance widening and the hit decision. Depends on sit_pkg, sit_div, sit_sqrt.
`include "segment_intersection_tolerant_assert.svh"
module sit_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [sit_pkg::TOLW-1:0]    tolerance,
  input  logic                        empty,
  input  sit_pkg::item_t              item,
  output logic                        pop,
  output logic                        done,
  output sit_pkg::result_t            result
);

  localparam int DXW  = sit_pkg::DXW;
  localparam int CPW  = sit_pkg::CPW;
  localparam int PW   = sit_pkg::PW;
  localparam int DETW = sit_pkg::DETW;
  localparam int CAW  = sit_pkg::CAW;
  localparam int LOW  = sit_pkg::LOW;
  localparam int HIW  = sit_pkg::HIW;
  localparam int NW   = sit_pkg::NW;
  localparam int BW   = sit_pkg::BW;
  localparam int EPSW = sit_pkg::EPSW;
  localparam int TOLW = sit_pkg::TOLW;

  localparam int S_SQ_OUT  = 2 + sit_pkg::SQB;
  localparam int S_EPS     = S_SQ_OUT + 2;
  localparam int S_WB      = S_EPS + 1;
  localparam int S_DIV_OUT = 4 + sit_pkg::DIV_LAT;
  localparam int S_OUT     = S_DIV_OUT + 1;

  assign pop = !empty;

  // stage 1: products
  logic signed [PW-1:0]  s1_det_a, s1_det_b, s1_sxa, s1_sya, s1_sxb, s1_syb;
  logic signed [CPW-1:0] s1_ca_a, s1_ca_b, s1_cb_a, s1_cb_b;
  logic signed [DXW-1:0] s1_dxa, s1_dya, s1_dxb, s1_dyb;

  always_ff @(posedge clk) begin
    s1_det_a <= item.dxa * item.dyb;
    s1_det_b <= item.dxb * item.dya;
    s1_ca_a  <= item.seg.a_start_x * item.seg.a_end_y;
    s1_ca_b  <= item.seg.a_end_x * item.seg.a_start_y;
    s1_cb_a  <= item.seg.b_start_x * item.seg.b_end_y;
    s1_cb_b  <= item.seg.b_end_x * item.seg.b_start_y;
    s1_sxa   <= item.dxa * item.dxa;
    s1_sya   <= item.dya * item.dya;
    s1_sxb   <= item.dxb * item.dxb;
    s1_syb   <= item.dyb * item.dyb;
    s1_dxa   <= item.dxa;
    s1_dya   <= item.dya;
    s1_dxb   <= item.dxb;
    s1_dyb   <= item.dyb;
  end

  // stage 2: determinant, cross terms, squared lengths
  logic signed [DETW-1:0] s2_det;
  logic signed [CAW-1:0]  s2_ca, s2_cb;
  logic [sit_pkg::SSW-1:0] s2_sa, s2_sb;
  logic signed [DXW-1:0]  s2_dxa, s2_dya, s2_dxb, s2_dyb;

  always_ff @(posedge clk) begin
    s2_det <= DETW'(s1_det_a) - DETW'(s1_det_b);
    s2_ca  <= CAW'(s1_ca_a) - CAW'(s1_ca_b);
    s2_cb  <= CAW'(s1_cb_a) - CAW'(s1_cb_b);
    s2_sa  <= $unsigned(s1_sxa) + $unsigned(s1_sya);
    s2_sb  <= $unsigned(s1_sxb) + $unsigned(s1_syb);
    s2_dxa <= s1_dxa;
    s2_dya <= s1_dya;
    s2_dxb <= s1_dxb;
    s2_dyb <= s1_dyb;
  end

  // stage 3: numerator partial products, cross terms split in two halves
  logic signed [HIW-1:0] ca_lo, ca_hi, cb_lo, cb_hi;
  logic signed [PW-1:0]  s3_xa_hi, s3_xa_lo, s3_xb_hi, s3_xb_lo;
  logic signed [PW-1:0]  s3_ya_hi, s3_ya_lo, s3_yb_hi, s3_yb_lo;
  logic signed [DETW-1:0] s3_det;

  assign ca_lo = signed'(HIW'(s2_ca[LOW-1:0]));
  assign cb_lo = signed'(HIW'(s2_cb[LOW-1:0]));
  assign ca_hi = s2_ca[CAW-1:LOW];
  assign cb_hi = s2_cb[CAW-1:LOW];

  always_ff @(posedge clk) begin
    s3_xa_hi <= s2_dxb * ca_hi;
    s3_xa_lo <= s2_dxb * ca_lo;
    s3_xb_hi <= s2_dxa * cb_hi;
    s3_xb_lo <= s2_dxa * cb_lo;
    s3_ya_hi <= s2_dyb * ca_hi;
    s3_ya_lo <= s2_dyb * ca_lo;
    s3_yb_hi <= s2_dya * cb_hi;
    s3_yb_lo <= s2_dya * cb_lo;
    s3_det   <= s2_det;
  end

  // stage 4: numerators
  logic signed [NW-1:0]   s4_nx, s4_ny;
  logic signed [DETW-1:0] s4_det;

  always_ff @(posedge clk) begin
    s4_nx  <= ((NW'(s3_xa_hi) <<< LOW) + NW'(s3_xa_lo)) -
              ((NW'(s3_xb_hi) <<< LOW) + NW'(s3_xb_lo));
    s4_ny  <= ((NW'(s3_ya_hi) <<< LOW) + NW'(s3_ya_lo)) -
              ((NW'(s3_yb_hi) <<< LOW) + NW'(s3_yb_lo));
    s4_det <= s3_det;
  end

  sit_pkg::div_res_t qx, qy;

  sit_div u_div_x (.clk(clk), .num(s4_nx), .den(s4_det), .res(qx));
  sit_div u_div_y (.clk(clk), .num(s4_ny), .den(s4_det), .res(qy));

  logic [sit_pkg::SQB-1:0] len_a, len_b;

  sit_sqrt u_sqrt_a (.clk(clk), .s(s2_sa), .root(len_a));
  sit_sqrt u_sqrt_b (.clk(clk), .s(s2_sb), .root(len_b));

  // tolerance widening: eps = floor(lmin * tol / 2^16)
  logic [EPSW-1:0]      lmin;
  logic [EPSW-1:0]      eps;
  logic [EPSW+TOLW-1:0] eps_prod;

  assign eps_prod = (EPSW+TOLW)'(lmin) * (EPSW+TOLW)'(tolerance);

  always_ff @(posedge clk) begin
    lmin <= (len_a < len_b) ? len_a : len_b;
    eps  <= eps_prod[EPSW+TOLW-1:TOLW];
  end

  // side lines carrying extents and flags alongside the arithmetic
  sit_pkg::bounds_t      bnd_line [1:S_EPS];
  sit_pkg::wide_bounds_t wb_line  [S_WB:S_DIV_OUT];
  logic                  dz_line  [3:S_DIV_OUT];
  logic                  v_line   [1:S_DIV_OUT];

  always_ff @(posedge clk) begin
    bnd_line[1] <= item.bnd;
    for (int k = 2; k <= S_EPS; k++) begin
      bnd_line[k] <= bnd_line[k-1];
    end
    dz_line[3] <= (s2_det == '0);
    for (int k = 4; k <= S_DIV_OUT; k++) begin
      dz_line[k] <= dz_line[k-1];
    end
    for (int k = S_WB + 1; k <= S_DIV_OUT; k++) begin
      wb_line[k] <= wb_line[k-1];
    end
  end

  always_ff @(posedge clk) begin
    wb_line[S_WB].ax_lo <= BW'(bnd_line[S_EPS].ax_lo) - BW'(eps);
    wb_line[S_WB].ax_hi <= BW'(bnd_line[S_EPS].ax_hi) + BW'(eps);
    wb_line[S_WB].bx_lo <= BW'(bnd_line[S_EPS].bx_lo) - BW'(eps);
    wb_line[S_WB].bx_hi <= BW'(bnd_line[S_EPS].bx_hi) + BW'(eps);
    wb_line[S_WB].ay_lo <= BW'(bnd_line[S_EPS].ay_lo) - BW'(eps);
    wb_line[S_WB].ay_hi <= BW'(bnd_line[S_EPS].ay_hi) + BW'(eps);
    wb_line[S_WB].by_lo <= BW'(bnd_line[S_EPS].by_lo) - BW'(eps);
    wb_line[S_WB].by_hi <= BW'(bnd_line[S_EPS].by_hi) + BW'(eps);
    wb_line[S_WB].boxes <= bnd_line[S_EPS].boxes;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= S_DIV_OUT; k++) begin
        v_line[k] <= 1'b0;
      end
      done <= 1'b0;
    end else begin
      v_line[1] <= pop;
      for (int k = 2; k <= S_DIV_OUT; k++) begin
        v_line[k] <= v_line[k-1];
      end
      done <= v_line[S_DIV_OUT];
    end
  end

  // final stage: extent tests and saturation
  sit_pkg::wide_bounds_t wb;
  logic                  dz;
  logic                  in_x, in_y;
  logic signed [sit_pkg::CW-1:0] sat_x, sat_y;

  assign wb = wb_line[S_DIV_OUT];
  assign dz = dz_line[S_DIV_OUT];

  always_comb begin
    in_x = !qx.ovf && (qx.q >= wb.ax_lo) && (qx.q <= wb.ax_hi) &&
           (qx.q >= wb.bx_lo) && (qx.q <= wb.bx_hi);
    in_y = !qy.ovf && (qy.q >= wb.ay_lo) && (qy.q <= wb.ay_hi) &&
           (qy.q >= wb.by_lo) && (qy.q <= wb.by_hi);
    if (qx.ovf) begin
      sat_x = qx.neg ? sit_pkg::C_MIN : sit_pkg::C_MAX;
    end else if (qx.q > sit_pkg::Q_MAX) begin
      sat_x = sit_pkg::C_MAX;
    end else if (qx.q < sit_pkg::Q_MIN) begin
      sat_x = sit_pkg::C_MIN;
    end else begin
      sat_x = qx.q[sit_pkg::CW-1:0];
    end
    if (qy.ovf) begin
      sat_y = qy.neg ? sit_pkg::C_MIN : sit_pkg::C_MAX;
    end else if (qy.q > sit_pkg::Q_MAX) begin
      sat_y = sit_pkg::C_MAX;
    end else if (qy.q < sit_pkg::Q_MIN) begin
      sat_y = sit_pkg::C_MIN;
    end else begin
      sat_y = qy.q[sit_pkg::CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    result.hit            <= wb.boxes && !dz && in_x && in_y;
    result.lines_parallel <= dz;
    result.cross_x        <= dz ? '0 : sat_x;
    result.cross_y        <= dz ? '0 : sat_y;
  end

  `SIT_ASSERT_IMPL(a_parallel_zero, done && result.lines_parallel, !result.hit && result.cross_x == '0 && result.cross_y == '0)
  `SIT_ASSERT(a_hit_not_parallel, !(done && result.hit && result.lines_parallel))
  `SIT_ASSERT_IMPL(a_pop_to_done, $past(pop, S_OUT), done)
  `SIT_ASSERT_IMPL(a_done_from_pop, done, $past(pop, S_OUT))

endmodule

// ===== rtl/segment_intersection_tolerant.sv =====
// Throughput: one request per cycle while busy is low; the divider and square-root pipelines
// each retire one result bit per stage and sustain a new item every cycle.
// Results appear for one cycle with done; the receiver cannot stall.
// Reset (rst, synchronous) empties the queue and pipeline and sets tolerance to 0.
module segment_intersection_tolerant (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  sit_pkg::seg_in_t          segs,
  output logic                      done,
  output sit_pkg::result_t          result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [sit_pkg::TOLW-1:0]  cfg_data
);

  logic [sit_pkg::TOLW-1:0] tolerance;
  logic                     full, empty, push, pop;
  sit_pkg::item_t           f_item, q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= '0;
    end else if (cfg_valid && cfg_ready) begin
      tolerance <= cfg_data;
    end
  end

  sit_front u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .segs(segs),
    .full(full), .push(push), .item(f_item)
  );

  sit_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .din(f_item), .pop(pop),
    .dout(q_item), .full(full), .empty(empty)
  );

  sit_back u_back (
    .clk(clk), .rst(rst), .tolerance(tolerance), .empty(empty), .item(q_item),
    .pop(pop), .done(done), .result(result)
  );

endmodule
